// ----- hw/rtl/fpc_pkg.sv -----
// Shared types and constants for the flow PID pump controller.
package fpc_pkg;

    localparam int GAIN_W  = 16;
    localparam int SET_W   = 24;
    localparam int ERR_W   = 25;
    localparam int DER_W   = 26;
    localparam int ACC_W   = 64;
    localparam int CNT_FLD = 12;
    localparam int STEP_W  = 4;

    localparam logic [1:0] FUNC_SAMPLE   = 2'd0;
    localparam logic [1:0] FUNC_PUMP_ON  = 2'd1;
    localparam logic [1:0] FUNC_PUMP_OFF = 2'd2;

    localparam logic [2:0] REG_SETPOINT   = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd3;
    localparam logic [2:0] REG_FLOW_GAIN  = 3'd4;

    localparam logic [SET_W-1:0]  SETPOINT_RST   = 24'd0;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd3277;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd590;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd429;
    localparam logic [GAIN_W-1:0] FLOW_GAIN_RST  = 16'd2612;

    localparam logic [7:0]        DUTY_MAX  = 8'd255;
    localparam logic [SET_W-1:0]  FLOW_MAX  = 24'hFFFFFF;
    localparam logic signed [ACC_W-1:0] IC_POS = 64'sd17592186044416;
    localparam logic signed [ACC_W-1:0] IC_NEG = -64'sd17592186044416;

    typedef struct packed {
        logic [1:0]         func;
        logic [CNT_FLD-1:0] pulse_count;
        logic               low_level;
    } in_t;

    typedef struct packed {
        logic [7:0]       duty;
        logic [SET_W-1:0] flow;
        logic             pump_running;
        logic             level_low;
    } out_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic step;
    } mac_ctrl_t;

endpackage

// ----- hw/rtl/fpc_mac.sv -----
// Bit-serial multiply-accumulate: one multiplier bit per cycle while step is asserted.
module fpc_mac import fpc_pkg::*; (
    input  logic                     aclk,
    input  mac_ctrl_t                ctrl,
    input  logic signed [ACC_W-1:0]  mcand_in,
    input  logic [GAIN_W-1:0]        mplier_in,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [ACC_W-1:0] mcand_reg;
    logic [GAIN_W-1:0]       mplier_reg;
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            mcand_reg  <= mcand_in;
            mplier_reg <= mplier_in;
            if (ctrl.clear) begin
                acc_reg <= '0;
            end
        end else if (ctrl.step) begin
            // add the shifted multiplicand when the current bit is set
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- hw/rtl/flow_pid_pump_controller_top.sv -----
// Flow PID pump controller: command decode, PID sequencer and result register.
//
// Input channel s_valid/s_ready/s_data carries one item: a sample-window end,
// a pump-on command or a pump-off command, each with the tank low-level bit.
// Only a sample produces a transaction on the result channel
// m_valid/m_ready/m_data (duty, flow, pump state, level echo).
// Configuration writes use cfg_wr_en/cfg_index/cfg_wr_data; a changed
// setpoint clears the PID state. A sample runs through a bit-serial
// multiplier, one product after another: flow product, then P, I and D
// products (only the flow product with the pump off).
// One sample is in work at a time; the next item is taken once the result
// is in the output register.
// Reset loads the register defaults, enables the pump and clears the duty,
// flow and PID state. If the receiver stalls, the result waits in the output
// register and the sequencer holds until it can be handed over.
module flow_pid_pump_controller_top import fpc_pkg::*; #(
    parameter int COUNT_WIDTH    = 12,
    parameter int INTEGRAL_WIDTH = 48
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [SET_W-1:0] cfg_wr_data
);

    localparam int IW = INTEGRAL_WIDTH;
    localparam logic [GAIN_W-1:0] CNT_MASK =
        GAIN_W'((32'd1 << COUNT_WIDTH) - 32'd1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FLOW = 4'd1;
    localparam logic [3:0] ST_FSAT = 4'd2;
    localparam logic [3:0] ST_ERR  = 4'd3;
    localparam logic [3:0] ST_P    = 4'd4;
    localparam logic [3:0] ST_LDI  = 4'd5;
    localparam logic [3:0] ST_I    = 4'd6;
    localparam logic [3:0] ST_LDD  = 4'd7;
    localparam logic [3:0] ST_D    = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    logic [3:0]              state_reg;
    logic [STEP_W-1:0]       cnt_reg;
    logic [SET_W-1:0]        setpoint_reg;
    logic [GAIN_W-1:0]       prop_gain_reg, integ_gain_reg, deriv_gain_reg, flow_gain_reg;
    logic                    pump_en_reg;
    logic signed [IW-1:0]    integ_reg;
    logic signed [ERR_W-1:0] last_err_reg;
    logic [7:0]              duty_reg;
    logic [SET_W-1:0]        flow_reg;
    logic                    low_reg;
    logic signed [ACC_W-1:0] ic_reg;
    logic signed [DER_W-1:0] d_reg;
    logic                    m_valid_reg;
    out_t                    m_data_reg;

    mac_ctrl_t               mac_ctrl;
    logic signed [ACC_W-1:0] mac_mcand;
    logic [GAIN_W-1:0]       mac_mplier;
    logic signed [ACC_W-1:0] acc;

    logic                    accept;
    logic signed [ERR_W-1:0] err;
    logic signed [IW:0]      isum;
    logic signed [IW-1:0]    integ_next;
    logic signed [ACC_W-1:0] integ_ext;
    logic signed [ACC_W-1:0] ic_next;
    logic signed [DER_W-1:0] d_next;
    logic [GAIN_W-1:0]       pulses;
    logic                    last_step;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign last_step = (cnt_reg == {STEP_W{1'b1}});
    assign pulses    = GAIN_W'(s_data.pulse_count) & CNT_MASK;

    // error, saturated integral, derivative
    always_comb begin
        err  = ERR_W'({1'b0, setpoint_reg}) - ERR_W'({1'b0, flow_reg});
        isum = (IW+1)'(integ_reg) + (IW+1)'(err);
        if (isum[IW] != isum[IW-1]) begin
            integ_next = isum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
            integ_next = isum[IW-1:0];
        end
        integ_ext = ACC_W'(integ_next);
        if (integ_ext > IC_POS) begin
            ic_next = IC_POS;
        end else if (integ_ext < IC_NEG) begin
            ic_next = IC_NEG;
        end else begin
            ic_next = integ_ext;
        end
        d_next = DER_W'(err) - DER_W'(last_err_reg);
    end

    always_comb begin
        mac_ctrl   = '0;
        mac_mcand  = ACC_W'({1'b0, pulses});
        mac_mplier = flow_gain_reg;
        unique case (state_reg)
            ST_IDLE: begin
                mac_ctrl.load  = accept && (s_data.func == FUNC_SAMPLE);
                mac_ctrl.clear = 1'b1;
            end
            ST_ERR: begin
                mac_ctrl.load  = 1'b1;
                mac_ctrl.clear = 1'b1;
                mac_mcand      = ACC_W'(err);
                mac_mplier     = prop_gain_reg;
            end
            ST_LDI: begin
                mac_ctrl.load = 1'b1;
                mac_mcand     = ic_reg;
                mac_mplier    = integ_gain_reg;
            end
            ST_LDD: begin
                mac_ctrl.load = 1'b1;
                mac_mcand     = ACC_W'(d_reg);
                mac_mplier    = deriv_gain_reg;
            end
            ST_FLOW, ST_P, ST_I, ST_D: begin
                mac_ctrl.step = 1'b1;
            end
            default: begin
                mac_ctrl = '0;
            end
        endcase
    end

    fpc_mac u_mac (
        .aclk      (aclk),
        .ctrl      (mac_ctrl),
        .mcand_in  (mac_mcand),
        .mplier_in (mac_mplier),
        .acc       (acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            setpoint_reg   <= SETPOINT_RST;
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            flow_gain_reg  <= FLOW_GAIN_RST;
            pump_en_reg    <= 1'b1;
            integ_reg      <= '0;
            last_err_reg   <= '0;
            duty_reg       <= '0;
            flow_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // the result stage reloads the register itself when it hands over
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_SETPOINT: begin
                        if (cfg_wr_data != setpoint_reg) begin
                            setpoint_reg <= cfg_wr_data;
                            integ_reg    <= '0;
                            last_err_reg <= '0;
                        end
                    end
                    REG_PROP_GAIN:  prop_gain_reg  <= cfg_wr_data[GAIN_W-1:0];
                    REG_INTEG_GAIN: integ_gain_reg <= cfg_wr_data[GAIN_W-1:0];
                    REG_DERIV_GAIN: deriv_gain_reg <= cfg_wr_data[GAIN_W-1:0];
                    REG_FLOW_GAIN:  flow_gain_reg  <= cfg_wr_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        low_reg <= s_data.low_level;
                        cnt_reg <= '0;
                        if (s_data.low_level || s_data.func == FUNC_PUMP_OFF) begin
                            pump_en_reg  <= 1'b0;
                            duty_reg     <= '0;
                            integ_reg    <= '0;
                            last_err_reg <= '0;
                        end else if (s_data.func == FUNC_PUMP_ON) begin
                            pump_en_reg <= 1'b1;
                        end
                        if (s_data.func == FUNC_SAMPLE) begin
                            state_reg <= ST_FLOW;
                        end
                    end
                end
                ST_FLOW, ST_P, ST_I, ST_D: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last_step) begin
                        state_reg <= state_reg + 4'd1;
                    end
                end
                ST_FSAT: begin
                    flow_reg  <= (acc[ACC_W-1:SET_W] != '0) ? FLOW_MAX : acc[SET_W-1:0];
                    state_reg <= pump_en_reg ? ST_ERR : ST_DONE;
                end
                ST_ERR: begin
                    integ_reg    <= integ_next;
                    last_err_reg <= err;
                    ic_reg       <= ic_next;
                    d_reg        <= d_next;
                    state_reg    <= ST_P;
                end
                ST_LDI, ST_LDD: begin
                    state_reg <= state_reg + 4'd1;
                end
                ST_OUT: begin
                    if (acc < 0) begin
                        duty_reg <= '0;
                    end else if (acc[ACC_W-1:32] != '0) begin
                        duty_reg <= DUTY_MAX;
                    end else begin
                        duty_reg <= acc[31:24];
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg              <= 1'b1;
                        m_data_reg.duty          <= duty_reg;
                        m_data_reg.flow          <= flow_reg;
                        m_data_reg.pump_running  <= pump_en_reg;
                        m_data_reg.level_low     <= low_reg;
                        state_reg                <= ST_IDLE;
                    end else begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/fpc_checker.sv -----
// Port-level checks for the flow PID pump controller, bound to the top level.
module fpc_checker import fpc_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped while stalled");

    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_SAMPLE |=> !s_ready)
        else $error("input taken during sample work");

    a_off_no_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.pump_running |-> m_data.duty == 8'd0)
        else $error("duty nonzero with pump stopped");

    a_low_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.level_low |-> !m_data.pump_running)
        else $error("pump running at low level");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind flow_pid_pump_controller_top fpc_checker u_fpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
